FILE: hw/rtl/b64d_pkg.sv
// Shared constants, result codes and character decode for the Base64 decoder.
package b64d_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int SYM_W       = 8;
    localparam int SEXTET_W    = 6;
    localparam int KIND_W      = 2;
    localparam int OUT_CNT_W   = 16;
    localparam int NSLOT       = 3;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [SYM_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [SYM_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PAD   = 8'h3D;

    localparam logic [SYM_W-1:0] OFS_LOWER = 8'd26;
    localparam logic [SYM_W-1:0] OFS_DIGIT = 8'd52;
    localparam logic [SEXTET_W-1:0] SX_PLUS  = 6'd62;
    localparam logic [SEXTET_W-1:0] SX_SLASH = 6'd63;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // {bad, value}
    function automatic logic [SEXTET_W:0] sextet_of(input logic [SYM_W-1:0] ch);
        logic [SEXTET_W:0] s;
        begin
            s = {1'b1, {SEXTET_W{1'b0}}};
            if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
                s = {1'b0, SEXTET_W'(ch - CH_UP_A)};
            end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
                s = {1'b0, SEXTET_W'(ch - CH_LO_A + OFS_LOWER)};
            end else if (ch >= CH_DIG_0 && ch <= CH_DIG_9) begin
                s = {1'b0, SEXTET_W'(ch - CH_DIG_0 + OFS_DIGIT)};
            end else if (ch == CH_PLUS) begin
                s = {1'b0, SX_PLUS};
            end else if (ch == CH_SLASH) begin
                s = {1'b0, SX_SLASH};
            end
            return s;
        end
    endfunction

    function automatic t_count sat_inc(input t_count x);
        begin
            return (x == '1) ? x : t_count'(x + 1'b1);
        end
    endfunction

endpackage

FILE: hw/rtl/base64_decoder_top.sv
// Base64 decoder top level: group assembly, byte extraction and three-deep result buffer.
// The first result word is valid in the cycle after the character word is accepted.
// Throughput: one character per cycle while the result side accepts; a word giving two or three results (a group of two
//   or three bytes, or an end marker after an open group) holds the input while the result buffer drains,
//   one word per cycle when the result side is ready.
// Reset: synchronous, active low; clears group state and count and empties the result buffer at once.
module base64_decoder_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [b64d_pkg::SYM_W-1:0]         i_symbol,
    input  logic                               i_end_marker,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [b64d_pkg::SYM_W-1:0]         o_data_byte,
    output logic [b64d_pkg::KIND_W-1:0]        o_kind,
    output logic [b64d_pkg::OUT_CNT_W-1:0]     o_decoded_count,
    output logic                               o_last
);
    import b64d_pkg::*;

    logic [1:0]          r_pos, n_pos;
    logic [SEXTET_W-1:0] r_held [3];
    logic [SEXTET_W-1:0] n_held [3];
    logic                r_third, n_third;
    logic                r_stop, n_stop;
    t_count              r_total, n_total;

    logic [1:0]          r_left;
    logic [1:0]          n_num;
    logic [SYM_W-1:0]    r_byte [NSLOT];
    logic [KIND_W-1:0]   r_kind [NSLOT];
    t_count              r_cnt  [NSLOT];
    logic [SYM_W-1:0]    n_byte [NSLOT];
    logic [KIND_W-1:0]   n_kind [NSLOT];
    t_count              n_cnt  [NSLOT];

    logic                accept, take;
    logic [SEXTET_W:0]   sx;
    logic                is_pad, pad_ok, bad;
    logic [SEXTET_W-1:0] v;
    t_count              c1, c2, c3;
    logic [SYM_W-1:0]    b0, b1, b2;

    assign o_out_valid     = (r_left != 2'd0);
    assign take            = o_out_valid && i_out_ready;
    assign o_in_ready      = (r_left == 2'd0) || (r_left == 2'd1 && i_out_ready);
    assign accept          = i_in_valid && o_in_ready;
    assign o_data_byte     = r_byte[0];
    assign o_kind          = r_kind[0];
    assign o_decoded_count = OUT_CNT_W'(r_cnt[0]);
    assign o_last          = (r_left == 2'd1);

    assign sx     = sextet_of(i_symbol);
    assign is_pad = (i_symbol == CH_PAD);
    assign pad_ok = is_pad && r_pos[1];
    assign bad    = sx[SEXTET_W] && !pad_ok;
    assign v      = pad_ok ? '0 : sx[SEXTET_W-1:0];

    assign c1 = sat_inc(r_total);
    assign c2 = sat_inc(c1);
    assign c3 = sat_inc(c2);

    assign b0 = {r_held[0], r_held[1][5:4]};
    assign b1 = {r_held[1][3:0], r_held[2][5:2]};
    assign b2 = {r_held[2][1:0], v};

    always_comb begin
        n_pos   = r_pos;
        n_held  = r_held;
        n_third = r_third;
        n_stop  = r_stop;
        n_total = r_total;
        n_num   = 2'd0;
        for (int k = 0; k < NSLOT; k++) begin
            n_byte[k] = '0;
            n_kind[k] = KIND_BYTE;
            n_cnt[k]  = r_total;
        end

        if (i_end_marker) begin
            if (!r_stop && r_pos != 2'd0) begin
                n_kind[0] = KIND_ERROR;
                n_kind[1] = KIND_DONE;
                n_num     = 2'd2;
            end else begin
                n_kind[0] = KIND_DONE;
                n_num     = 2'd1;
            end
            n_pos   = '0;
            n_held  = '{default: '0};
            n_third = 1'b0;
            n_stop  = 1'b0;
            n_total = '0;
        end else if (r_stop) begin
            n_num = 2'd0;
        end else if (bad) begin
            n_kind[0] = KIND_ERROR;
            n_num     = 2'd1;
            n_stop    = 1'b1;
        end else if (r_pos != 2'd3) begin
            n_held[r_pos] = v;
            if (r_pos == 2'd2) begin
                n_third = is_pad;
            end
            n_pos = r_pos + 2'd1;
        end else begin
            n_byte[0] = b0;
            n_cnt[0]  = c1;
            n_byte[1] = b1;
            n_cnt[1]  = c2;
            n_byte[2] = b2;
            n_cnt[2]  = c3;
            if (r_third) begin
                n_num   = 2'd1;
                n_total = c1;
            end else if (is_pad) begin
                n_num   = 2'd2;
                n_total = c2;
            end else begin
                n_num   = 2'd3;
                n_total = c3;
            end
            n_pos   = '0;
            n_held  = '{default: '0};
            n_third = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_held  <= '{default: '0};
            r_third <= 1'b0;
            r_stop  <= 1'b0;
            r_total <= '0;
            r_left  <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_third <= n_third;
            r_stop  <= n_stop;
            r_total <= n_total;
            r_left  <= n_num;
        end else if (take) begin
            r_left  <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= n_byte;
            r_kind <= n_kind;
            r_cnt  <= n_cnt;
        end else if (take) begin
            for (int k = 0; k < NSLOT - 1; k++) begin
                r_byte[k] <= r_byte[k+1];
                r_kind[k] <= r_kind[k+1];
                r_cnt[k]  <= r_cnt[k+1];
            end
        end
    end

endmodule

FILE: hw/rtl/b64d_checker.sv
// Port-level checks on the Base64 decoder result channel, bound to the top level.
module b64d_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [b64d_pkg::SYM_W-1:0]         o_data_byte,
    input  logic [b64d_pkg::KIND_W-1:0]        o_kind,
    input  logic [b64d_pkg::OUT_CNT_W-1:0]     o_decoded_count,
    input  logic                               o_last
);
    import b64d_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_kind) && $stable(o_decoded_count) && $stable(o_last))
        else $error("result word changed while stalled");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_BYTE |-> o_data_byte == '0)
        else $error("status word carries a data byte");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE |-> o_last)
        else $error("done word not marked last");

    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside the words of one character");

    a_no_input_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken while earlier words still pending");

endmodule

bind base64_decoder_top b64d_checker u_b64d_checker (.*);

FILE: dv/b64d_tb_pkg.sv
// Scoreboard for the Base64 decoder bench: predicts decoded words and checks them in order.
package b64d_tb_pkg;

    import b64d_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0]     data;
        logic [KIND_W-1:0]    kind;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } t_result_word;

    class b64_byte_predictor;
        t_count              byte_total;
        logic [1:0]          slot;
        logic [SEXTET_W-1:0] held [3];
        logic                third_pad;
        logic                halted;
        t_result_word        expected_words [$];
        int unsigned         fail_count;

        function new();
            fail_count = 0;
            clear_text();
        endfunction

        function void clear_text();
            byte_total = '0;
            slot       = '0;
            held       = '{default: '0};
            third_pad  = 1'b0;
            halted     = 1'b0;
        endfunction

        function int sextet_value(input logic [SYM_W-1:0] ch);
            if (ch inside {[CH_UP_A:CH_UP_Z]}) return int'(ch - CH_UP_A);
            if (ch inside {[CH_LO_A:CH_LO_Z]}) return int'(ch - CH_LO_A) + int'(OFS_LOWER);
            if (ch inside {[CH_DIG_0:CH_DIG_9]}) return int'(ch - CH_DIG_0) + int'(OFS_DIGIT);
            if (ch == CH_PLUS) return int'(SX_PLUS);
            if (ch == CH_SLASH) return int'(SX_SLASH);
            return -1;
        endfunction

        function void push_word(input logic [SYM_W-1:0] data, input logic [KIND_W-1:0] kind,
                                input logic last);
            t_result_word w;
            w.data  = data;
            w.kind  = kind;
            w.count = byte_total[OUT_CNT_W-1:0];
            w.last  = last;
            expected_words.push_back(w);
        endfunction

        function void push_byte(input logic [SYM_W-1:0] data, input logic last);
            if (byte_total != '1) byte_total++;
            push_word(data, KIND_BYTE, last);
        endfunction

        function void take_char(input logic [SYM_W-1:0] ch, input logic end_marker);
            int               sx;
            logic             is_pad;
            logic [SYM_W-1:0] b0;
            logic [SYM_W-1:0] b1;
            logic [SYM_W-1:0] b2;
            if (end_marker) begin
                if (!halted && slot != 0) push_word('0, KIND_ERROR, 1'b0);
                push_word('0, KIND_DONE, 1'b1);
                clear_text();
                return;
            end
            if (halted) return;
            sx     = sextet_value(ch);
            is_pad = (ch == CH_PAD);
            if (is_pad && slot >= 2) begin
                sx = 0;
            end else if (sx < 0) begin
                halted = 1'b1;
                push_word('0, KIND_ERROR, 1'b1);
                return;
            end
            if (slot != 2'd3) begin
                held[slot] = sx[SEXTET_W-1:0];
                if (slot == 2'd2) third_pad = is_pad;
                slot++;
                return;
            end
            b0 = {held[0], held[1][5:4]};
            b1 = {held[1][3:0], held[2][5:2]};
            b2 = {held[2][1:0], sx[SEXTET_W-1:0]};
            if (third_pad) begin
                push_byte(b0, 1'b1);
            end else begin
                push_byte(b0, 1'b0);
                if (is_pad) begin
                    push_byte(b1, 1'b1);
                end else begin
                    push_byte(b1, 1'b0);
                    push_byte(b2, 1'b1);
                end
            end
            slot      = '0;
            third_pad = 1'b0;
            held      = '{default: '0};
        endfunction

        function void check_word(input t_result_word got);
            t_result_word want;
            if (expected_words.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word data=%02h kind=%0d count=%0d last=%0b",
                         $time, got.data, got.kind, got.count, got.last);
                return;
            end
            want = expected_words.pop_front();
            if (got.data != want.data || got.kind != want.kind ||
                got.count != want.count || got.last != want.last) begin
                fail_count++;
                $display({"%0t: mismatch expected data=%02h kind=%0d count=%0d last=%0b",
                          " actual data=%02h kind=%0d count=%0d last=%0b"},
                         $time, want.data, want.kind, want.count, want.last,
                         got.data, got.kind, got.count, got.last);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level bench for base64_decoder_top: directed and random texts.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;
    import b64d_tb_pkg::*;

    typedef enum int {PAD_NONE, PAD_LAST, PAD_BOTH, PAD_THIRD} t_pad_shape;

    localparam int PHASE_WORDS  = 117;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [SYM_W-1:0]     i_symbol;
    logic                 i_end_marker;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SYM_W-1:0]     o_data_byte;
    logic [KIND_W-1:0]    o_kind;
    logic [OUT_CNT_W-1:0] o_decoded_count;
    logic                 o_last;

    int unsigned       src_idle_pct;
    int unsigned       sink_idle_pct;
    int unsigned       words_sent;
    b64_byte_predictor predictor;

    base64_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_symbol        (i_symbol),
        .i_end_marker    (i_end_marker),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_data_byte     (o_data_byte),
        .o_kind          (o_kind),
        .o_decoded_count (o_decoded_count),
        .o_last          (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predictor.take_char(i_symbol, i_end_marker);
            if (o_out_valid && i_out_ready)
                predictor.check_word('{o_data_byte, o_kind, o_decoded_count, o_last});
        end
    end

    function automatic logic [SYM_W-1:0] b64_char(input logic [SEXTET_W-1:0] sx);
        if (sx < SEXTET_W'(OFS_LOWER)) return CH_UP_A + SYM_W'(sx);
        if (sx < SEXTET_W'(OFS_DIGIT)) return CH_LO_A + SYM_W'(sx) - OFS_LOWER;
        if (sx < SX_PLUS) return CH_DIG_0 + SYM_W'(sx) - OFS_DIGIT;
        if (sx == SX_PLUS) return CH_PLUS;
        return CH_SLASH;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [SYM_W-1:0] sym, input logic end_marker);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_symbol     <= sym;
        i_end_marker <= end_marker;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_word(s[k], 1'b0);
    endtask

    task automatic send_end();
        send_word(SYM_W'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_group(input t_pad_shape shape);
        logic [SYM_W-1:0] c [4];
        for (int k = 0; k < 4; k++) c[k] = b64_char(SEXTET_W'($urandom_range(63)));
        case (shape)
            PAD_LAST: c[3] = CH_PAD;
            PAD_BOTH: begin
                c[2] = CH_PAD;
                c[3] = CH_PAD;
            end
            PAD_THIRD: c[2] = CH_PAD;
            default: ;
        endcase
        for (int k = 0; k < 4; k++) send_word(c[k], 1'b0);
    endtask

    task automatic send_random_text();
        int groups;
        int len;
        if ($urandom_range(99) < 75) begin
            groups = $urandom_range(5);
            for (int g = 0; g < groups; g++) send_group(PAD_NONE);
            if ($urandom_range(1)) send_group(t_pad_shape'($urandom_range(3)));
        end else begin
            len = $urandom_range(1, 9);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(2))
                    0: send_word(SYM_W'($urandom_range(255)), 1'b0);
                    1: send_word(b64_char(SEXTET_W'($urandom_range(63))), 1'b0);
                    default: send_word(CH_PAD, 1'b0);
                endcase
            end
        end
        send_end();
    endtask

    initial begin
        predictor     = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_symbol      = '0;
        i_end_marker  = 1'b0;
        i_out_ready   = 1'b0;
        src_idle_pct  = 33;
        sink_idle_pct = 85;
        words_sent    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("TWFu");
        send_text("+/9=");
        send_text("za==");
        send_text("AZ=0");
        send_end();
        send_text("Q");
        send_end();
        send_text("A=");
        send_word(8'hFF, 1'b0);
        send_end();
        send_word(8'h00, 1'b0);
        send_end();

        while (words_sent < PHASE_WORDS) send_random_text();
        src_idle_pct  = 85;
        sink_idle_pct = 33;
        while (words_sent < 2 * PHASE_WORDS) send_random_text();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (words_sent < 3 * PHASE_WORDS) send_random_text();

        i_in_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (predictor.fail_count == 0) begin
            $display("base64_decoder_top regression: pass");
        end else begin
            $display("base64_decoder_top regression: fail");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("base64_decoder_top regression: fail");
        $finish;
    end

endmodule
